[hdl/csm_pkg.sv]
// Shared widths, op codes and controller/datapath bundles for the stack machine.
`default_nettype none
package csm_pkg;
    localparam int DATA_W      = 31;
    localparam int LIM_W       = 30;
    localparam int OP_W        = 4;
    localparam int DEPTH_DEF   = 1024;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 30'd1000000000;

    localparam logic [OP_W-1:0] OP_START = 4'd0;
    localparam logic [OP_W-1:0] OP_NUM   = 4'd1;
    localparam logic [OP_W-1:0] OP_POP   = 4'd2;
    localparam logic [OP_W-1:0] OP_INV   = 4'd3;
    localparam logic [OP_W-1:0] OP_DUP   = 4'd4;
    localparam logic [OP_W-1:0] OP_SWP   = 4'd5;
    localparam logic [OP_W-1:0] OP_ADD   = 4'd6;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd7;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd8;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd9;
    localparam logic [OP_W-1:0] OP_MOD   = 4'd10;
    localparam logic [OP_W-1:0] OP_END   = 4'd11;

    typedef enum logic [2:0] {
        DP_NOP, DP_START, DP_PUSH_V, DP_PUSH_TOS, DP_POP, DP_INV, DP_SWP, DP_COMMIT
    } t_dp_op;

    typedef enum logic [2:0] {
        RS_SUM, RS_DIFF, RS_PROD, RS_QUO, RS_REM
    } t_res_sel;

    typedef struct packed {
        t_dp_op   op;
        t_res_sel sel;
        logic     set_err;
        logic     mul_go;
        logic     div_go;
        logic     nos_load;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic lt2;
        logic full;
        logic err;
        logic a_zero;
        logic add_ovf;
        logic sub_ovf;
        logic mul_ovf;
        logic div_done;
        logic out_busy;
    } t_dp_sts;
endpackage
`default_nettype wire

[hdl/csm_if.sv]
// Valid/ready channel interfaces for instruction and result beats.
`default_nettype none
interface csm_in_if;
    import csm_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic signed [DATA_W-1:0] value;
    modport source (output valid, op, value, input ready);
    modport sink   (input valid, op, value, output ready);
endinterface

interface csm_out_if;
    import csm_pkg::*;
    logic              valid;
    logic              ready;
    logic signed [DATA_W-1:0] result_value;
    logic              failed;
    modport source (output valid, result_value, failed, input ready);
    modport sink   (input valid, result_value, failed, output ready);
endinterface
`default_nettype wire

[hdl/csm_div.sv]
// Restoring signed divider, one quotient bit per cycle.
`default_nettype none
module csm_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [csm_pkg::DATA_W-1:0] i_dividend,
    input  wire logic signed [csm_pkg::DATA_W-1:0] i_divisor,
    output logic                                   o_done,
    output logic signed [csm_pkg::DATA_W-1:0]      o_quot,
    output logic signed [csm_pkg::DATA_W-1:0]      o_rem
);
    import csm_pkg::*;
    localparam int STEP_W = $clog2(DATA_W);
    localparam logic [STEP_W-1:0] LAST = STEP_W'(DATA_W - 1);

    logic [DATA_W-1:0] r_q, r_r, r_d;
    logic              r_qneg, r_rneg, r_busy, r_done;
    logic [STEP_W-1:0] r_step;
    logic [DATA_W:0]   rem_sh;
    logic              ge;

    assign rem_sh = {r_r, r_q[DATA_W-1]};
    assign ge     = rem_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == LAST) begin
                r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_q    <= i_dividend[DATA_W-1] ? DATA_W'(-i_dividend) : i_dividend;
            r_d    <= i_divisor[DATA_W-1] ? DATA_W'(-i_divisor) : i_divisor;
            r_r    <= '0;
            r_step <= '0;
            r_qneg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            r_rneg <= i_dividend[DATA_W-1];
        end else if (r_busy) begin
            r_r    <= ge ? DATA_W'(rem_sh - {1'b0, r_d}) : rem_sh[DATA_W-1:0];
            r_q    <= {r_q[DATA_W-2:0], ge};
            r_step <= r_step + STEP_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_qneg ? DATA_W'(-r_q) : r_q;
    assign o_rem  = r_rneg ? DATA_W'(-r_r) : r_r;
endmodule
`default_nettype wire

[hdl/csm_dp.sv]
// Datapath: cached top entries, stack memory, ALU, limit register, result register.
`default_nettype none
module csm_dp #(
    parameter int DEPTH = csm_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire csm_pkg::t_dp_cmd                  i_cmd,
    input  wire logic signed [csm_pkg::DATA_W-1:0] i_value,
    input  wire logic                              i_cfg_we,
    input  wire logic [csm_pkg::LIM_W-1:0]         i_cfg_data,
    input  wire logic                              i_out_ready,
    output csm_pkg::t_dp_sts                       o_sts,
    output logic                                   o_out_valid,
    output logic signed [csm_pkg::DATA_W-1:0]      o_result_value,
    output logic                                   o_failed
);
    import csm_pkg::*;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = 2 * DATA_W;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] r_tos, r_nos, r_rdata, r_res;
    logic [CW-1:0]            r_cnt;
    logic                     r_err, r_ov, r_fail;
    logic [LIM_W-1:0]         r_lim;
    logic signed [PW-1:0]     r_prod;
    logic signed [DATA_W:0]   sum, diff;
    logic [DATA_W:0]          sum_mag, diff_mag;
    logic [PW-1:0]            prod_mag;
    logic signed [DATA_W-1:0] quot, rem, res;
    logic                     div_done;
    logic [CW-1:0]            rd_idx, wr_idx;

    csm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (r_nos),
        .i_divisor  (r_tos),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    assign sum      = {r_nos[DATA_W-1], r_nos} + {r_tos[DATA_W-1], r_tos};
    assign diff     = {r_nos[DATA_W-1], r_nos} - {r_tos[DATA_W-1], r_tos};
    assign sum_mag  = sum[DATA_W] ? (DATA_W+1)'(-sum) : sum;
    assign diff_mag = diff[DATA_W] ? (DATA_W+1)'(-diff) : diff;
    assign prod_mag = r_prod[PW-1] ? PW'(-r_prod) : r_prod;

    always_comb begin
        unique case (i_cmd.sel)
            RS_SUM:  res = sum[DATA_W-1:0];
            RS_DIFF: res = diff[DATA_W-1:0];
            RS_PROD: res = r_prod[DATA_W-1:0];
            RS_QUO:  res = quot;
            RS_REM:  res = rem;
            default: res = quot;
        endcase
    end

    // memory holds entries below the two cached ones
    assign rd_idx = r_cnt - CW'(3);
    assign wr_idx = r_cnt - CW'(2);

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[rd_idx[AW-1:0]];
        if ((i_cmd.op == DP_PUSH_V || i_cmd.op == DP_PUSH_TOS) && r_cnt >= CW'(2)) begin
            mem[wr_idx[AW-1:0]] <= r_nos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_err <= 1'b0;
            r_lim <= LIMIT_RESET;
            r_ov  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lim <= i_cfg_data;
            end
            if (i_cmd.set_err) begin
                r_err <= 1'b1;
            end
            unique case (i_cmd.op)
                DP_START: begin
                    r_cnt <= CW'(1);
                    r_err <= 1'b0;
                end
                DP_PUSH_V, DP_PUSH_TOS: r_cnt <= r_cnt + CW'(1);
                DP_POP, DP_COMMIT:      r_cnt <= r_cnt - CW'(1);
                default: ;
            endcase
            r_ov <= i_cmd.out_load | (r_ov & ~i_out_ready);
        end
        unique case (i_cmd.op)
            DP_START:    r_tos <= i_value;
            DP_PUSH_V: begin
                r_tos <= i_value;
                r_nos <= r_tos;
            end
            DP_PUSH_TOS: r_nos <= r_tos;
            DP_POP:      r_tos <= r_nos;
            DP_INV:      r_tos <= DATA_W'(-r_tos);
            DP_SWP: begin
                r_tos <= r_nos;
                r_nos <= r_tos;
            end
            DP_COMMIT:   r_tos <= res;
            default: ;
        endcase
        if (i_cmd.nos_load) begin
            r_nos <= r_rdata;
        end
        if (i_cmd.mul_go) begin
            r_prod <= r_nos * r_tos;
        end
        if (i_cmd.out_load) begin
            r_fail <= r_err || (r_cnt != CW'(1));
            r_res  <= (r_err || (r_cnt != CW'(1))) ? '0 : r_tos;
        end
    end

    assign o_sts.empty    = (r_cnt == '0);
    assign o_sts.lt2      = (r_cnt < CW'(2));
    assign o_sts.full     = (r_cnt == CW'(DEPTH));
    assign o_sts.err      = r_err;
    assign o_sts.a_zero   = (r_tos == '0);
    assign o_sts.add_ovf  = sum_mag > (DATA_W+1)'(r_lim);
    assign o_sts.sub_ovf  = diff_mag > (DATA_W+1)'(r_lim);
    assign o_sts.mul_ovf  = prod_mag > PW'(r_lim);
    assign o_sts.div_done = div_done;
    assign o_sts.out_busy = r_ov;

    assign o_out_valid    = r_ov;
    assign o_result_value = r_res;
    assign o_failed       = r_fail;
endmodule
`default_nettype wire

[hdl/csm_ctrl.sv]
// Controller: decodes instruction beats and sequences the datapath.
`default_nettype none
module csm_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic [csm_pkg::OP_W-1:0]      i_op,
    input  wire logic                          i_out_ready,
    input  wire csm_pkg::t_dp_sts              i_sts,
    output logic                               o_in_ready,
    output csm_pkg::t_dp_cmd                   o_cmd
);
    import csm_pkg::*;
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_LD} t_state;

    t_state   r_state, n_state;
    t_res_sel r_dsel, n_dsel;
    logic     take;

    assign o_in_ready = (r_state == S_IDLE) &&
                        (!i_sts.out_busy || i_out_ready || i_op != OP_END);
    assign take = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd   = '{op: DP_NOP, sel: RS_SUM, default: 1'b0};
        n_state = r_state;
        n_dsel  = r_dsel;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (i_op == OP_START) begin
                        o_cmd.op = DP_START;
                    end else if (i_op == OP_END) begin
                        o_cmd.out_load = 1'b1;
                    end else if (!i_sts.err) begin
                        unique case (i_op)
                            OP_NUM: begin
                                if (i_sts.full) o_cmd.set_err = 1'b1;
                                else o_cmd.op = DP_PUSH_V;
                            end
                            OP_POP: begin
                                if (i_sts.empty) o_cmd.set_err = 1'b1;
                                else begin
                                    o_cmd.op = DP_POP;
                                    n_state  = S_LD;
                                end
                            end
                            OP_INV: begin
                                if (i_sts.empty) o_cmd.set_err = 1'b1;
                                else o_cmd.op = DP_INV;
                            end
                            OP_DUP: begin
                                if (i_sts.empty || i_sts.full) o_cmd.set_err = 1'b1;
                                else o_cmd.op = DP_PUSH_TOS;
                            end
                            OP_SWP: begin
                                if (i_sts.lt2) o_cmd.set_err = 1'b1;
                                else o_cmd.op = DP_SWP;
                            end
                            OP_ADD, OP_SUB: begin
                                if (i_sts.lt2 ||
                                    (i_op == OP_ADD ? i_sts.add_ovf : i_sts.sub_ovf)) begin
                                    o_cmd.set_err = 1'b1;
                                end else begin
                                    o_cmd.op  = DP_COMMIT;
                                    o_cmd.sel = (i_op == OP_ADD) ? RS_SUM : RS_DIFF;
                                    n_state   = S_LD;
                                end
                            end
                            OP_MUL: begin
                                if (i_sts.lt2) o_cmd.set_err = 1'b1;
                                else begin
                                    o_cmd.mul_go = 1'b1;
                                    n_state      = S_MUL;
                                end
                            end
                            OP_DIV, OP_MOD: begin
                                if (i_sts.lt2 || i_sts.a_zero) o_cmd.set_err = 1'b1;
                                else begin
                                    o_cmd.div_go = 1'b1;
                                    n_dsel       = (i_op == OP_DIV) ? RS_QUO : RS_REM;
                                    n_state      = S_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_MUL: begin
                if (i_sts.mul_ovf) begin
                    o_cmd.set_err = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.op  = DP_COMMIT;
                    o_cmd.sel = RS_PROD;
                    n_state   = S_LD;
                end
            end
            S_DIV: begin
                o_cmd.sel = r_dsel;
                if (i_sts.div_done) begin
                    o_cmd.op = DP_COMMIT;
                    n_state  = S_LD;
                end
            end
            S_LD: begin
                o_cmd.nos_load = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dsel  <= RS_QUO;
        end else begin
            r_state <= n_state;
            r_dsel  <= n_dsel;
        end
    end
endmodule
`default_nettype wire

[hdl/checked_stack_machine_core.sv]
// Top level of the checked integer stack machine.
//
//  channel  | dir | handshake            | payload
//  i_in     | in  | valid/ready          | op[3:0], value[30:0] signed
//  o_out    | out | valid/ready          | result_value[30:0] signed, failed
//  i_cfg_*  | in  | write enable, no ack | magnitude_limit[29:0]
//
// Start, end, num, inv, dup, swp and any op that errors at decode finish in the
// idle state that takes them; pop, add and sub then refill the second cached
// entry from the stack RAM; mul registers the product, then checks the limit and
// either returns to idle or commits and refills; div/mod launch the 31-step
// restoring divider, wait for its done, then commit and refill.
// Reset is synchronous, active low; it empties the stack, clears the error and
// the result valid and loads the limit with its default. The stack RAM is
// not cleared. A result beat waits in its own register; new non-end beats are
// taken while it waits, an end beat waits until the slot frees.
`default_nettype none
module checked_stack_machine_core #(
    parameter int STACK_DEPTH = csm_pkg::DEPTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    csm_in_if.sink                         i_in,
    csm_out_if.source                      o_out,
    input  wire logic                      i_cfg_we,
    input  wire logic [csm_pkg::LIM_W-1:0] i_cfg_data
);
    import csm_pkg::*;

    t_dp_cmd cmd;   // controller -> datapath
    t_dp_sts sts;   // datapath -> controller

    csm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_op        (i_in.op),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_cmd       (cmd)
    );

    // stack, ALU, divider and the result register
    csm_dp #(
        .DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_value        (i_in.value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (o_out.ready),
        .o_sts          (sts),
        .o_out_valid    (o_out.valid),
        .o_result_value (o_out.result_value),
        .o_failed       (o_out.failed)
    );

    // a result beat only appears after an accepted end beat
    a_out_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(i_in.valid && i_in.ready && i_in.op == OP_END))
        else $error("result beat without end beat");

    // the divider owns the machine while it runs
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_go |=> !i_in.ready)
        else $error("beat accepted during divide");

    // multiply and divide never launch together
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.mul_go && cmd.div_go))
        else $error("mul and div launched together");
endmodule
`default_nettype wire
